// File: rtl/ovd_pkg.sv
// Shared constants and a helper function for the octant downsample pipeline.
package ovd_pkg;

    localparam int CHANNEL_BITS_DEF = 4;
    localparam int NUM_CHILDREN     = 8;
    localparam int NUM_RGB          = 3;
    localparam int FACES_PER_CHILD  = 3;
    localparam int FACE_MASK_W      = NUM_CHILDREN * FACES_PER_CHILD;
    // Weight of one child is 0..3, the face total is 0..24.
    localparam int WEIGHT_W         = 2;
    localparam int TOTAL_W          = 5;
    // Extra bits above a channel for one weighted product and for the sum of eight.
    localparam int PROD_EXTRA       = 2;
    localparam int SUM_EXTRA        = 5;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Number of set bits in a three-bit face group.
    function automatic logic [WEIGHT_W-1:0] pop3(input logic [FACES_PER_CHILD-1:0] v);
        logic [WEIGHT_W-1:0] s;
        s = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
        return s;
    endfunction

endpackage

// File: rtl/ovd_in_if.sv
// Request channel carrying one 2x2x2 block of child voxels.
interface ovd_in_if
    import ovd_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [3*CHANNEL_BITS-1:0]    child_colour_0;
    logic [3*CHANNEL_BITS-1:0]    child_colour_1;
    logic [3*CHANNEL_BITS-1:0]    child_colour_2;
    logic [3*CHANNEL_BITS-1:0]    child_colour_3;
    logic [3*CHANNEL_BITS-1:0]    child_colour_4;
    logic [3*CHANNEL_BITS-1:0]    child_colour_5;
    logic [3*CHANNEL_BITS-1:0]    child_colour_6;
    logic [3*CHANNEL_BITS-1:0]    child_colour_7;
    logic [NUM_CHILDREN-1:0]      solid_mask;
    logic [FACE_MASK_W-1:0]       open_face_mask;

    modport source
    (
        output valid,
        output child_colour_0, child_colour_1, child_colour_2, child_colour_3,
        output child_colour_4, child_colour_5, child_colour_6, child_colour_7,
        output solid_mask, open_face_mask,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  child_colour_0, child_colour_1, child_colour_2, child_colour_3,
        input  child_colour_4, child_colour_5, child_colour_6, child_colour_7,
        input  solid_mask, open_face_mask,
        output ready
    );
endinterface

// File: rtl/ovd_out_if.sv
// Result channel carrying one coarse voxel.
interface ovd_out_if
    import ovd_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
    logic [CHANNEL_BITS-1:0] out_alpha;

    modport source
    (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );

    modport sink
    (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

// File: rtl/voxel_octant_face_weighted_downsample.sv
// Top level of the octant downsampler: weighting, divider and output register.
//
// Takes one 2x2x2 block of child voxels per request and returns one coarse voxel per
// request, in order. A block whose eight children are all solid yields the average
// child colour weighted by each child's count of exposed outer faces (truncated, a
// face total of zero counts as one) with full alpha; any other block yields all
// zeros. The pipeline accepts one request per clock while the output is not stalled:
// two stages form the weighted products and sums, the divider spends one stage per
// quotient bit (CHANNEL_BITS stages), and a final output register holds the result.
// Backpressure stalls only stages that hold data, so bubbles are squeezed out while
// the output waits.
module voxel_octant_face_weighted_downsample
    import ovd_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    ovd_in_if.sink      voxels,
    ovd_out_if.source   result
);

    localparam int SW = CHANNEL_BITS + SUM_EXTRA;

    logic                    acc_valid;
    logic                    acc_ready;
    logic [SW-1:0]           acc_sum [NUM_RGB];
    logic [TOTAL_W-1:0]      acc_total;
    logic                    acc_solid;

    logic                    div_valid;
    logic                    div_ready;
    logic [CHANNEL_BITS-1:0] div_q [NUM_RGB];
    logic                    div_solid;

    logic                    out_valid_reg;
    logic [CHANNEL_BITS-1:0] red_reg;
    logic [CHANNEL_BITS-1:0] green_reg;
    logic [CHANNEL_BITS-1:0] blue_reg;
    logic [CHANNEL_BITS-1:0] alpha_reg;

    ovd_accum #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .voxels (voxels),
        .valid  (acc_valid),
        .ready  (acc_ready),
        .sum    (acc_sum),
        .total  (acc_total),
        .solid  (acc_solid)
    );

    ovd_divide #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc_valid),
        .in_ready  (acc_ready),
        .sum       (acc_sum),
        .total     (acc_total),
        .solid     (acc_solid),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .quotient  (div_q),
        .out_solid (div_solid)
    );

    assign div_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_ready)
        begin
            out_valid_reg <= div_valid;
        end
    end

    // A block that is not fully solid gives zeros whatever the divider produced.
    always_ff @(posedge clk)
    begin
        if (div_valid && div_ready)
        begin
            red_reg   <= div_solid ? div_q[CH_RED]   : '0;
            green_reg <= div_solid ? div_q[CH_GREEN] : '0;
            blue_reg  <= div_solid ? div_q[CH_BLUE]  : '0;
            alpha_reg <= {CHANNEL_BITS{div_solid}};
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_red   = red_reg;
    assign result.out_green = green_reg;
    assign result.out_blue  = blue_reg;
    assign result.out_alpha = alpha_reg;

`ifndef SYNTHESIS
    a_alpha_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (alpha_reg == '0 || alpha_reg == '1))
        else $error("alpha is neither transparent nor full scale");

    a_empty_is_black: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && alpha_reg == '0) |->
            (red_reg == '0 && green_reg == '0 && blue_reg == '0))
        else $error("transparent result carries a colour");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !voxels.ready |-> (out_valid_reg && !result.ready))
        else $error("input stalled while the output was free");
`endif

endmodule

// File: rtl/ovd_accum.sv
// Two pipeline stages: per-child face weighting, then the weighted sums and face total.
module ovd_accum
    import ovd_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    ovd_in_if.sink                                     voxels,
    output logic                                       valid,
    input  logic                                       ready,
    output logic [CHANNEL_BITS+SUM_EXTRA-1:0]          sum [NUM_RGB],
    output logic [TOTAL_W-1:0]                         total,
    output logic                                       solid
);

    localparam int PW = CHANNEL_BITS + PROD_EXTRA;
    localparam int SW = CHANNEL_BITS + SUM_EXTRA;

    logic [3*CHANNEL_BITS-1:0] colour [NUM_CHILDREN];

    logic                valid_a_reg;
    logic                solid_a_reg;
    logic [PW-1:0]       prod_reg [NUM_CHILDREN][NUM_RGB];
    logic [PW-1:0]       prod_next [NUM_CHILDREN][NUM_RGB];
    logic [WEIGHT_W-1:0] weight_reg [NUM_CHILDREN];
    logic [WEIGHT_W-1:0] weight_next [NUM_CHILDREN];

    logic                valid_b_reg;
    logic                solid_b_reg;
    logic [SW-1:0]       sum_reg [NUM_RGB];
    logic [SW-1:0]       sum_next [NUM_RGB];
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;

    logic                rdy_a;
    logic                rdy_b;

    assign colour[0] = voxels.child_colour_0;
    assign colour[1] = voxels.child_colour_1;
    assign colour[2] = voxels.child_colour_2;
    assign colour[3] = voxels.child_colour_3;
    assign colour[4] = voxels.child_colour_4;
    assign colour[5] = voxels.child_colour_5;
    assign colour[6] = voxels.child_colour_6;
    assign colour[7] = voxels.child_colour_7;

    assign rdy_b        = !valid_b_reg || ready;
    assign rdy_a        = !valid_a_reg || rdy_b;
    assign voxels.ready = rdy_a;

    // Weight 0..3 times a channel is at most two shifted adds.
    always_comb
    begin
        logic [CHANNEL_BITS-1:0] ch;
        for (int i = 0; i < NUM_CHILDREN; i++)
        begin
            weight_next[i] = pop3(voxels.open_face_mask[FACES_PER_CHILD*i +: FACES_PER_CHILD]);
            for (int c = 0; c < NUM_RGB; c++)
            begin
                ch = colour[i][CHANNEL_BITS*(NUM_RGB-1-c) +: CHANNEL_BITS];
                prod_next[i][c] = ({2'b00, ch} & {PW{weight_next[i][0]}})
                                + ({1'b0, ch, 1'b0} & {PW{weight_next[i][1]}});
            end
        end
    end

    always_comb
    begin
        logic [TOTAL_W-1:0] t;
        t = '0;
        for (int c = 0; c < NUM_RGB; c++)
        begin
            sum_next[c] = '0;
        end
        for (int i = 0; i < NUM_CHILDREN; i++)
        begin
            t = t + TOTAL_W'(weight_reg[i]);
            for (int c = 0; c < NUM_RGB; c++)
            begin
                sum_next[c] = sum_next[c] + SW'(prod_reg[i][c]);
            end
        end
        // A block with no exposed face divides by one.
        total_next = (t == '0) ? TOTAL_W'(1) : t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                valid_a_reg <= voxels.valid;
            end
            if (rdy_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (voxels.valid && rdy_a)
        begin
            solid_a_reg <= &voxels.solid_mask;
            prod_reg    <= prod_next;
            weight_reg  <= weight_next;
        end
        if (valid_a_reg && rdy_b)
        begin
            solid_b_reg <= solid_a_reg;
            sum_reg     <= sum_next;
            total_reg   <= total_next;
        end
    end

    assign valid = valid_b_reg;
    assign sum   = sum_reg;
    assign total = total_reg;
    assign solid = solid_b_reg;

`ifndef SYNTHESIS
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_b_reg |-> total_reg != '0)
        else $error("face total reached the divider as zero");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_b_reg |-> total_reg <= TOTAL_W'(FACE_MASK_W))
        else $error("face total exceeds the number of outer faces");
`endif

endmodule

// File: rtl/ovd_divide.sv
// Pipelined restoring divider: one quotient bit per stage for all three channels.
module ovd_divide
    import ovd_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [CHANNEL_BITS+SUM_EXTRA-1:0]   sum [NUM_RGB],
    input  logic [TOTAL_W-1:0]                  total,
    input  logic                                solid,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [CHANNEL_BITS-1:0]             quotient [NUM_RGB],
    output logic                                out_solid
);

    localparam int SW = CHANNEL_BITS + SUM_EXTRA;
    localparam int NS = CHANNEL_BITS;

    logic                    valid_reg [NS];
    logic                    solid_reg [NS];
    logic [TOTAL_W-1:0]      total_reg [NS];
    logic [SW-1:0]           rem_reg   [NS][NUM_RGB];
    logic [CHANNEL_BITS-1:0] q_reg     [NS][NUM_RGB];
    logic                    rdy       [NS+1];

    assign rdy[NS]  = out_ready;
    assign in_ready = rdy[0];

    // The quotient never exceeds the channel range, so the first stage tests the top
    // quotient bit and each later stage the next one down.
    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam int B = NS - 1 - k;

        logic                    src_valid;
        logic                    src_solid;
        logic [TOTAL_W-1:0]      src_total;
        logic [SW-1:0]           src_rem [NUM_RGB];
        logic [CHANNEL_BITS-1:0] src_q   [NUM_RGB];
        logic [SW:0]             divisor;
        logic [SW-1:0]           rem_next [NUM_RGB];
        logic [CHANNEL_BITS-1:0] q_next   [NUM_RGB];

        if (k == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_solid = solid;
            assign src_total = total;
            for (genvar c = 0; c < NUM_RGB; c++)
            begin : g_ch
                assign src_rem[c] = sum[c];
                assign src_q[c]   = '0;
            end
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[k-1];
            assign src_solid = solid_reg[k-1];
            assign src_total = total_reg[k-1];
            for (genvar c = 0; c < NUM_RGB; c++)
            begin : g_ch
                assign src_rem[c] = rem_reg[k-1][c];
                assign src_q[c]   = q_reg[k-1][c];
            end
        end

        assign rdy[k]  = !valid_reg[k] || rdy[k+1];
        assign divisor = (SW+1)'(src_total) << B;

        always_comb
        begin
            logic [SW:0] diff;
            for (int c = 0; c < NUM_RGB; c++)
            begin
                diff = {1'b0, src_rem[c]} - divisor;
                if ({1'b0, src_rem[c]} >= divisor)
                begin
                    rem_next[c] = diff[SW-1:0];
                    q_next[c]   = src_q[c] | (CHANNEL_BITS'(1) << B);
                end
                else
                begin
                    rem_next[c] = src_rem[c];
                    q_next[c]   = src_q[c];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (src_valid && rdy[k])
            begin
                solid_reg[k] <= src_solid;
                total_reg[k] <= src_total;
                rem_reg[k]   <= rem_next;
                q_reg[k]     <= q_next;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_solid = solid_reg[NS-1];
    assign quotient  = q_reg[NS-1];

endmodule

// File: tb/voxel_octant_face_weighted_downsample_tb.sv
// Self-checking testbench for the face-weighted 2x2x2 voxel downsampler.
`timescale 1ns / 100ps

module voxel_octant_face_weighted_downsample_tb;
    import ovd_pkg::*;

    localparam int CB           = CHANNEL_BITS_DEF;
    localparam int COLOUR_W     = NUM_RGB * CB;
    localparam int RANDOM_ITEMS = 450;
    localparam int FIRST_CHUNK  = 200;
    localparam int QUIET_TAIL   = 60;
    localparam int LONG_STALL   = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 40000;

    typedef struct packed {
        logic [NUM_CHILDREN-1:0][COLOUR_W-1:0] colour;
        logic [NUM_CHILDREN-1:0]               solid;
        logic [FACE_MASK_W-1:0]                faces;
    } octant_t;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
        logic [CB-1:0] alpha;
    } coarse_t;

    logic clk;
    logic rst_n;

    ovd_in_if  #(.CHANNEL_BITS(CB)) voxels_if ();
    ovd_out_if #(.CHANNEL_BITS(CB)) result_if ();

    voxel_octant_face_weighted_downsample #(.CHANNEL_BITS(CB)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .voxels (voxels_if),
        .result (result_if)
    );

    octant_t block_queue[$];
    coarse_t coarse_expected[$];

    int      requests_queued = 0;
    int      requests_taken  = 0;
    int      quiet_from      = 0;
    int      mismatches      = 0;
    int      cycle_count     = 0;
    int      send_gap        = 0;
    int      hold_off        = 0;
    bit      long_stall_done = 1'b0;
    bit      req_taken       = 1'b0;
    octant_t next_block;
    octant_t offered;
    coarse_t returned;
    coarse_t wanted;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic coarse_t coarse_voxel_of(octant_t blk);
        coarse_t     v;
        int unsigned sums [NUM_RGB];
        int unsigned weight;
        int unsigned total;
        v     = '0;
        total = 0;
        sums  = '{default: 0};
        if (blk.solid != '1)
        begin
            return v;
        end
        for (int i = 0; i < NUM_CHILDREN; i++)
        begin
            weight = unsigned'($countones(blk.faces[FACES_PER_CHILD*i +: FACES_PER_CHILD]));
            total += weight;
            for (int ch = CH_RED; ch <= CH_BLUE; ch++)
            begin
                sums[ch] += weight * blk.colour[i][(NUM_RGB-1-ch)*CB +: CB];
            end
        end
        // A block with no exposed face divides by one and so comes out black.
        if (total == 0)
        begin
            total = 1;
        end
        v.red   = CB'(sums[CH_RED] / total);
        v.green = CB'(sums[CH_GREEN] / total);
        v.blue  = CB'(sums[CH_BLUE] / total);
        v.alpha = '1;
        return v;
    endfunction

    function automatic octant_t uniform_octant(logic [COLOUR_W-1:0] colour,
                                               logic [NUM_CHILDREN-1:0] solid,
                                               logic [FACE_MASK_W-1:0] faces);
        octant_t o;
        for (int i = 0; i < NUM_CHILDREN; i++)
        begin
            o.colour[i] = colour;
        end
        o.solid = solid;
        o.faces = faces;
        return o;
    endfunction

    function automatic octant_t random_octant();
        octant_t o;
        for (int i = 0; i < NUM_CHILDREN; i++)
        begin
            o.colour[i] = COLOUR_W'($urandom_range(0, (1 << COLOUR_W) - 1));
            if ($urandom_range(0, 7) == 0)
            begin
                o.colour[i] = $urandom_range(0, 1) ? '1 : '0;
            end
        end
        // Mostly fully solid blocks, since only those exercise the divider.
        case ($urandom_range(0, 9))
            0:       o.solid = NUM_CHILDREN'($urandom);
            1:
            begin
                o.solid = '1;
                o.solid[$urandom_range(0, NUM_CHILDREN-1)] = 1'b0;
            end
            default: o.solid = '1;
        endcase
        case ($urandom_range(0, 7))
            0:       o.faces = '0;
            1:       o.faces = '1;
            2:       o.faces = FACE_MASK_W'($urandom & $urandom & $urandom);
            default: o.faces = FACE_MASK_W'($urandom);
        endcase
        return o;
    endfunction

    task automatic queue_octant(octant_t o);
        block_queue.push_back(o);
        requests_queued++;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic wait_for_drain();
        while (requests_taken != requests_queued || coarse_expected.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Sender: holds a request until it is taken, then maybe idles for a burst.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            voxels_if.valid <= 1'b0;
        end
        else if (voxels_if.valid && !req_taken)
        begin
        end
        else if (send_gap > 0)
        begin
            voxels_if.valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (block_queue.size() > 0)
        begin
            next_block = block_queue.pop_front();
            voxels_if.child_colour_0 <= next_block.colour[0];
            voxels_if.child_colour_1 <= next_block.colour[1];
            voxels_if.child_colour_2 <= next_block.colour[2];
            voxels_if.child_colour_3 <= next_block.colour[3];
            voxels_if.child_colour_4 <= next_block.colour[4];
            voxels_if.child_colour_5 <= next_block.colour[5];
            voxels_if.child_colour_6 <= next_block.colour[6];
            voxels_if.child_colour_7 <= next_block.colour[7];
            voxels_if.solid_mask     <= next_block.solid;
            voxels_if.open_face_mask <= next_block.faces;
            voxels_if.valid          <= 1'b1;
            if (requests_taken < quiet_from && $urandom_range(0, 5) == 0)
            begin
                send_gap <= $urandom_range(1, 4);
            end
        end
        else
        begin
            voxels_if.valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off that backs up the pipeline.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            result_if.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (!long_stall_done && requests_taken >= 100)
        begin
            result_if.ready <= 1'b0;
            hold_off <= LONG_STALL - 1;
            long_stall_done <= 1'b1;
        end
        else if (requests_taken < quiet_from && $urandom_range(0, 5) == 0)
        begin
            result_if.ready <= 1'b0;
            hold_off <= $urandom_range(0, 3);
        end
        else
        begin
            result_if.ready <= 1'b1;
        end
    end

    // Monitor: checks each returned voxel, then records the request taken at this edge.
    always @(posedge clk)
    begin
        req_taken <= voxels_if.valid && voxels_if.ready;
        if (result_if.valid && result_if.ready)
        begin
            returned = {result_if.out_red, result_if.out_green,
                        result_if.out_blue, result_if.out_alpha};
            if (coarse_expected.size() == 0)
            begin
                report_mismatch("result with no request outstanding", int'(returned), 0);
            end
            else
            begin
                wanted = coarse_expected.pop_front();
                if (returned.red !== wanted.red)
                begin
                    report_mismatch("out_red", int'(returned.red), int'(wanted.red));
                end
                if (returned.green !== wanted.green)
                begin
                    report_mismatch("out_green", int'(returned.green), int'(wanted.green));
                end
                if (returned.blue !== wanted.blue)
                begin
                    report_mismatch("out_blue", int'(returned.blue), int'(wanted.blue));
                end
                if (returned.alpha !== wanted.alpha)
                begin
                    report_mismatch("out_alpha", int'(returned.alpha), int'(wanted.alpha));
                end
            end
        end
        if (voxels_if.valid && voxels_if.ready)
        begin
            offered.colour[0] = voxels_if.child_colour_0;
            offered.colour[1] = voxels_if.child_colour_1;
            offered.colour[2] = voxels_if.child_colour_2;
            offered.colour[3] = voxels_if.child_colour_3;
            offered.colour[4] = voxels_if.child_colour_4;
            offered.colour[5] = voxels_if.child_colour_5;
            offered.colour[6] = voxels_if.child_colour_6;
            offered.colour[7] = voxels_if.child_colour_7;
            offered.solid     = voxels_if.solid_mask;
            offered.faces     = voxels_if.open_face_mask;
            coarse_expected.push_back(coarse_voxel_of(offered));
            requests_taken <= requests_taken + 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        octant_t o;
        clk                      = 1'b0;
        rst_n                    = 1'b0;
        voxels_if.valid          = 1'b0;
        voxels_if.child_colour_0 = '0;
        voxels_if.child_colour_1 = '0;
        voxels_if.child_colour_2 = '0;
        voxels_if.child_colour_3 = '0;
        voxels_if.child_colour_4 = '0;
        voxels_if.child_colour_5 = '0;
        voxels_if.child_colour_6 = '0;
        voxels_if.child_colour_7 = '0;
        voxels_if.solid_mask     = '0;
        voxels_if.open_face_mask = '0;
        result_if.ready          = 1'b0;

        // Extremes of colour and face weight, then blocks that are not fully solid.
        queue_octant(uniform_octant('0, '1, '1));
        queue_octant(uniform_octant('1, '1, '1));
        queue_octant(uniform_octant('1, '1, '0));
        queue_octant(uniform_octant('1, '0, '1));
        queue_octant(uniform_octant('1, 8'h7f, '1));
        queue_octant(uniform_octant('1, 8'hfe, '1));
        queue_octant(uniform_octant('1, 8'hef, '0));
        // One exposed face in the whole block picks that child's colour exactly.
        o = random_octant();
        o.solid = '1;
        o.faces = 24'h000001;
        queue_octant(o);
        // Checkerboard colours against alternating face patterns.
        for (int i = 0; i < NUM_CHILDREN; i++)
        begin
            o.colour[i] = (i % 2) ? 12'h5a5 : 12'ha5a;
        end
        o.faces = 24'haaaaaa;
        queue_octant(o);
        o.faces = 24'h555555;
        queue_octant(o);
        o.faces = '1;
        queue_octant(o);
        for (int i = 0; i < NUM_CHILDREN; i++)
        begin
            o.colour[i] = {4'(i), 4'(15 - i), 4'(2 * i)};
        end
        o.faces = FACE_MASK_W'($urandom);
        queue_octant(o);
        // A single bright, fully exposed child among dark, hidden ones.
        for (int k = 0; k < NUM_CHILDREN; k++)
        begin
            o = uniform_octant('0, '1, '0);
            o.colour[k] = '1;
            o.faces[FACES_PER_CHILD*k +: FACES_PER_CHILD] = '1;
            queue_octant(o);
        end
        quiet_from = requests_queued + RANDOM_ITEMS - QUIET_TAIL;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait_for_drain();
        for (int n = 0; n < FIRST_CHUNK; n++)
        begin
            queue_octant(random_octant());
        end
        // The sender goes quiet here until the pipeline has emptied.
        wait_for_drain();
        for (int n = FIRST_CHUNK; n < RANDOM_ITEMS; n++)
        begin
            queue_octant(random_octant());
        end
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/ovd_pkg.sv
rtl/ovd_in_if.sv
rtl/ovd_out_if.sv
rtl/ovd_accum.sv
rtl/ovd_divide.sv
rtl/voxel_octant_face_weighted_downsample.sv
tb/voxel_octant_face_weighted_downsample_tb.sv
